// ===== hdl/register_pool_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Register pool allocator assertion macros
// Shared assertion forms for the checker of the register pool allocator.
// ----------------------------------------------------------------------------
`ifndef REGISTER_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define REGISTER_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Register pool allocator package
// Payload types, request and status codes and configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

	localparam int REGS_PER_CLASS_DEF = 8;
	localparam int NUM_CLASSES_DEF    = 3;
	localparam int CFG_CLASSES        = 3;

	localparam logic [3:0] COUNT_MAX   = 4'd15;
	localparam logic [3:0] COUNT_RESET = 4'd8;

	localparam logic [1:0] MODE_RESET    = 2'd0;
	localparam logic [1:0] MODE_ANY      = 2'd1;
	localparam logic [1:0] MODE_SPECIFIC = 2'd2;
	localparam logic [1:0] MODE_RELEASE  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_INUSE  = 2'd2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START2 = 3'd5;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] reg_class;
		logic [4:0] reg_index;
	} rpa_in_t;

	typedef struct packed {
		logic [4:0] granted_reg;
		logic [1:0] status;
		logic [3:0] avail_count;
		logic [4:0] lowest_used;
	} rpa_out_t;

endpackage

`default_nettype wire

// ===== hdl/register_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Register pool allocator
// Keeps in-use flags, available counts and lowest-in-use marks for a pool of
// NUM_CLASSES classes of REGS_PER_CLASS registers. One flag comparator is
// stepped by a small sequencer, one flag per cycle, and one request is
// served at a time; the result waits in an output register.
// A pool reset sweeps every flag, allocate-any scans its class flag by flag,
// allocate-specific and release search the classes for the owner, and a
// request for a class or register outside the pool goes straight to the
// result. The next request is taken when the sequencer is back in idle.
// Reset clears all flags, loads counts of 8 and marks of (c + 1) *
// REGS_PER_CLASS, and loads the configuration registers with 8, 16, 24, 8, 8, 8.
// ----------------------------------------------------------------------------
`default_nettype none

module register_pool_allocator_unit #(
	parameter int REGS_PER_CLASS = rpa_pkg::REGS_PER_CLASS_DEF,
	parameter int NUM_CLASSES    = rpa_pkg::NUM_CLASSES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire rpa_pkg::rpa_in_t                 in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output rpa_pkg::rpa_out_t                     out_data,
	input  wire logic                             cfg_wr_en,
	input  wire logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rpa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import rpa_pkg::*;

	localparam int POOL      = REGS_PER_CLASS * NUM_CLASSES;
	localparam int PTW       = $clog2(POOL);
	localparam int PVW       = $clog2(POOL + 1);
	localparam int CW        = (PVW > 5) ? PVW : 5;
	localparam int OW        = $clog2(REGS_PER_CLASS);
	localparam int CLW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int DEF_START = (REGS_PER_CLASS > 15) ? 15 : REGS_PER_CLASS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FIND  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]     state_q;
	logic [1:0]     mode_q;
	logic [1:0]     req_cls_q;
	logic [PTW-1:0] ptr_q;
	logic [OW-1:0]  off_q;
	logic [CLW-1:0] rc_q;
	logic [CW-1:0]  base_q;
	logic           rep_ok_q;
	logic [4:0]     granted_q;
	logic [1:0]     status_q;

	logic [POOL-1:0] flags_q;
	logic [3:0]      counts_q [NUM_CLASSES];
	logic [CW-1:0]   lowest_q [NUM_CLASSES];

	logic [3:0] first0_q;
	logic [4:0] first1_q;
	logic [4:0] first2_q;
	logic [3:0] start_q [CFG_CLASSES];

	logic          out_valid_q;
	rpa_out_t      out_q;

	logic [CW-1:0] first_tab [NUM_CLASSES];
	logic [3:0]    start_tab [NUM_CLASSES];
	logic          accept;
	logic          in_cls_ok;
	logic [CW-1:0] in_idx_ext;
	logic          flag_rd;
	logic [3:0]    cnt_rd;
	logic [3:0]    cnt_dec;
	logic [3:0]    cnt_inc;
	logic [CW-1:0] ptr_ext;
	logic          out_free;
	rpa_out_t      res;

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (c == 0) begin
				first_tab[c] = CW'(first0_q);
				start_tab[c] = start_q[0];
			end else if (c == 1) begin
				first_tab[c] = CW'(first1_q);
				start_tab[c] = start_q[1];
			end else if (c == 2) begin
				first_tab[c] = CW'(first2_q);
				start_tab[c] = start_q[2];
			end else begin
				first_tab[c] = CW'((c + 1) * REGS_PER_CLASS);
				start_tab[c] = 4'(DEF_START);
			end
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign in_cls_ok  = (int'(in_data.reg_class) < NUM_CLASSES);
	assign in_idx_ext = CW'(in_data.reg_index);
	assign flag_rd    = flags_q[ptr_q];
	assign cnt_rd     = counts_q[rc_q];
	assign cnt_dec    = (cnt_rd == 4'd0) ? 4'd0 : cnt_rd - 4'd1;
	assign cnt_inc    = (cnt_rd == COUNT_MAX) ? COUNT_MAX : cnt_rd + 4'd1;
	assign ptr_ext    = CW'(ptr_q);
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		res.granted_reg = granted_q;
		res.status      = status_q;
		res.avail_count = rep_ok_q ? cnt_rd : 4'd0;
		res.lowest_used = rep_ok_q ? lowest_q[rc_q][4:0] : 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first0_q <= 4'd8;
			first1_q <= 5'd16;
			first2_q <= 5'd24;
			for (int c = 0; c < CFG_CLASSES; c++) begin
				start_q[c] <= COUNT_RESET;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FIRST0: first0_q   <= cfg_wdata[3:0];
				CFG_FIRST1: first1_q   <= cfg_wdata;
				CFG_FIRST2: first2_q   <= cfg_wdata;
				CFG_START0: start_q[0] <= cfg_wdata[3:0];
				CFG_START1: start_q[1] <= cfg_wdata[3:0];
				CFG_START2: start_q[2] <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				counts_q[c] <= COUNT_RESET;
				lowest_q[c] <= CW'((c + 1) * REGS_PER_CLASS);
			end
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= in_data.mode;
						req_cls_q <= in_data.reg_class;
						case (in_data.mode)
							MODE_RESET: begin
								granted_q <= 5'd0;
								status_q  <= ST_OK;
								rep_ok_q  <= in_cls_ok;
								ptr_q     <= '0;
								off_q     <= '0;
								rc_q      <= '0;
								state_q   <= S_SWEEP;
							end
							MODE_ANY: begin
								granted_q <= 5'd0;
								if (!in_cls_ok) begin
									status_q <= ST_NOFREE;
									rep_ok_q <= 1'b0;
									state_q  <= S_DONE;
								end else begin
									rep_ok_q <= 1'b1;
									rc_q     <= CLW'(in_data.reg_class);
									ptr_q    <= PTW'(int'(in_data.reg_class) * REGS_PER_CLASS
										+ REGS_PER_CLASS - 1);
									off_q    <= OW'(REGS_PER_CLASS - 1);
									state_q  <= S_SCAN;
								end
							end
							default: begin
								granted_q <= in_data.reg_index;
								if (in_idx_ext >= CW'(POOL)) begin
									status_q <= (in_data.mode == MODE_SPECIFIC) ? ST_INUSE : ST_OK;
									rep_ok_q <= 1'b0;
									state_q  <= S_DONE;
								end else begin
									ptr_q   <= PTW'(in_data.reg_index);
									rc_q    <= '0;
									base_q  <= '0;
									state_q <= S_FIND;
								end
							end
						endcase
					end
				end
				S_SWEEP: begin
					flags_q[ptr_q] <= (ptr_ext >= first_tab[rc_q]);
					ptr_q          <= PTW'(ptr_q + 1'b1);
					if (off_q == OW'(REGS_PER_CLASS - 1)) begin
						lowest_q[rc_q] <= first_tab[rc_q];
						counts_q[rc_q] <= start_tab[rc_q];
						off_q          <= '0;
						if (rc_q == CLW'(NUM_CLASSES - 1)) begin
							rc_q    <= CLW'(req_cls_q);
							state_q <= S_DONE;
						end else begin
							rc_q <= CLW'(rc_q + 1'b1);
						end
					end else begin
						off_q <= OW'(off_q + 1'b1);
					end
				end
				S_SCAN: begin
					if (!flag_rd) begin
						flags_q[ptr_q] <= 1'b1;
						counts_q[rc_q] <= cnt_dec;
						if (ptr_ext < lowest_q[rc_q]) begin
							lowest_q[rc_q] <= ptr_ext;
						end
						granted_q <= 5'(ptr_q);
						status_q  <= ST_OK;
						state_q   <= S_DONE;
					end else if (off_q == '0) begin
						status_q <= ST_NOFREE;
						state_q  <= S_DONE;
					end else begin
						ptr_q <= PTW'(ptr_q - 1'b1);
						off_q <= OW'(off_q - 1'b1);
					end
				end
				S_FIND: begin
					if (ptr_ext < CW'(base_q + CW'(REGS_PER_CLASS))) begin
						rep_ok_q <= 1'b1;
						state_q  <= S_DONE;
						if (mode_q == MODE_RELEASE) begin
							flags_q[ptr_q] <= 1'b0;
							counts_q[rc_q] <= cnt_inc;
							status_q       <= ST_OK;
						end else if (flag_rd) begin
							status_q <= ST_INUSE;
						end else begin
							flags_q[ptr_q] <= 1'b1;
							counts_q[rc_q] <= cnt_dec;
							if (ptr_ext < lowest_q[rc_q]) begin
								lowest_q[rc_q] <= ptr_ext;
							end
							status_q <= ST_OK;
						end
					end else begin
						base_q <= CW'(base_q + CW'(REGS_PER_CLASS));
						rc_q   <= CLW'(rc_q + 1'b1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== hdl/rpa_checker.sv =====
// ----------------------------------------------------------------------------
// Register pool allocator checker
// Port-level assertions on the allocator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_pool_allocator_unit_defines.svh"

module rpa_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire rpa_pkg::rpa_out_t              out_data
);
	import rpa_pkg::*;

	`RPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
		"Stalled result transaction changed or dropped.")
	`RPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"Allocator took a second transaction while one was still in work.")
	`RPA_ASSERT_SAME(a_nofree_zero, out_valid && out_data.status == ST_NOFREE,
		out_data.granted_reg == 5'd0, "Failed allocation reported a nonzero register.")
	`RPA_ASSERT_SAME(a_status_code, out_valid, out_data.status == ST_OK
		|| out_data.status == ST_NOFREE || out_data.status == ST_INUSE,
		"Result transaction carries an undefined status code.")

endmodule

bind register_pool_allocator_unit rpa_checker u_rpa_checker (.*);

`default_nettype wire

// ===== dv/register_pool_allocator_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Register pool allocator checker
// Watches the request, result and configuration ports of the allocator and
// keeps its own copy of the flags, counts, marks and configuration. Every
// accepted request is turned into the result it must produce. Every accepted
// result is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module register_pool_allocator_unit_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire rpa_pkg::rpa_in_t               in_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire rpa_pkg::rpa_out_t              out_data,
	input  wire logic                           cfg_wr_en,
	input  wire logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                  errors,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rpa_pkg::*;

	localparam int REGS    = REGS_PER_CLASS_DEF;
	localparam int CLASSES = NUM_CLASSES_DEF;
	localparam int POOL    = REGS * CLASSES;

	logic [POOL-1:0] used_map;
	logic [3:0]      free_cnt  [CLASSES];
	logic [4:0]      low_mark  [CLASSES];
	logic [4:0]      first_cfg [CFG_CLASSES];
	logic [3:0]      start_cfg [CFG_CLASSES];
	rpa_out_t        answers_due[$];

	function automatic void claim(int r);
		int c;
		c = r / REGS;
		used_map[r] = 1'b1;
		if (r < low_mark[c])
			low_mark[c] = 5'(r);
		if (free_cnt[c] != 4'd0)
			free_cnt[c] = free_cnt[c] - 4'd1;
	endfunction

	function automatic rpa_out_t pool_answer(rpa_in_t req);
		rpa_out_t ans;
		int       cls;
		int       idx;
		int       owner;
		int       r;
		ans   = '0;
		cls   = req.reg_class;
		idx   = req.reg_index;
		owner = -1;
		case (req.mode)
			MODE_RESET: begin
				for (int c = 0; c < CLASSES; c++) begin
					for (int i = 0; i < REGS; i++)
						used_map[c*REGS+i] = (c * REGS + i >= first_cfg[c]);
					low_mark[c] = first_cfg[c];
					free_cnt[c] = start_cfg[c];
				end
				ans.status = ST_OK;
				if (cls < CLASSES)
					owner = cls;
			end
			MODE_ANY: begin
				ans.status = ST_NOFREE;
				if (cls < CLASSES) begin
					owner = cls;
					for (int i = REGS - 1; i >= 0; i--) begin
						r = cls * REGS + i;
						if (ans.status == ST_NOFREE && !used_map[r]) begin
							claim(r);
							ans.granted_reg = 5'(r);
							ans.status = ST_OK;
						end
					end
				end
			end
			MODE_SPECIFIC: begin
				ans.granted_reg = req.reg_index;
				ans.status = ST_INUSE;
				if (idx < POOL) begin
					owner = idx / REGS;
					if (!used_map[idx]) begin
						claim(idx);
						ans.status = ST_OK;
					end
				end
			end
			MODE_RELEASE: begin
				ans.granted_reg = req.reg_index;
				ans.status = ST_OK;
				if (idx < POOL) begin
					owner = idx / REGS;
					used_map[idx] = 1'b0;
					if (free_cnt[owner] != COUNT_MAX)
						free_cnt[owner] = free_cnt[owner] + 4'd1;
				end
			end
		endcase
		if (owner >= 0) begin
			ans.avail_count = free_cnt[owner];
			ans.lowest_used = low_mark[owner];
		end
		return ans;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpa_out_t want;
		if (!arst_n) begin
			used_map = '0;
			for (int c = 0; c < CLASSES; c++) begin
				free_cnt[c] = COUNT_RESET;
				low_mark[c] = 5'((c + 1) * REGS);
			end
			for (int c = 0; c < CFG_CLASSES; c++) begin
				first_cfg[c] = 5'((c + 1) * REGS);
				start_cfg[c] = COUNT_RESET;
			end
			answers_due.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FIRST0: first_cfg[0] = {1'b0, cfg_wdata[3:0]};
					CFG_FIRST1: first_cfg[1] = cfg_wdata;
					CFG_FIRST2: first_cfg[2] = cfg_wdata;
					CFG_START0: start_cfg[0] = cfg_wdata[3:0];
					CFG_START1: start_cfg[1] = cfg_wdata[3:0];
					CFG_START2: start_cfg[2] = cfg_wdata[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				answers_due.push_back(pool_answer(in_data));
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$error("result transaction with no request outstanding: %p", out_data);
					errors++;
				end else begin
					want = answers_due.pop_front();
					check_field("granted_reg", want.granted_reg, out_data.granted_reg);
					check_field("status", want.status, out_data.status);
					check_field("avail_count", want.avail_count, out_data.avail_count);
					check_field("lowest_used", want.lowest_used, out_data.lowest_used);
				end
			end
			pending = answers_due.size();
		end
	end

endmodule

// ===== dv/register_pool_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Register pool allocator testbench
// Drives allocate, release and pool reset requests into the allocator under
// several configurations, with random gaps on the request side and random
// stalls on the result side. A checker beside the block predicts and
// compares every result; this module only makes stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module register_pool_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpa_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  out_stall = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	rpa_in_t               in_data   = '0;
	logic                  in_stall;
	logic                  out_valid;
	rpa_out_t              out_data;
	int                    errors;
	int                    pending;
	bit                    calm      = 1'b0;

	always #5 clk = ~clk;

	register_pool_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	register_pool_allocator_unit_checker checker_inst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always begin
		@(negedge clk);
		if (!calm && arst_n && $urandom_range(0, 3) == 0) begin
			out_stall = 1'b1;
			repeat (pick_gap() + 1) @(negedge clk);
			out_stall = 1'b0;
		end
	end

	task automatic send_request(logic [1:0] mode, logic [1:0] cls, logic [4:0] idx);
		int gap;
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = '{mode: mode, reg_class: cls, reg_index: idx};
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = CFG_DATA_W'(value);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic load_setting(int f0, int f1, int f2, int s0, int s1, int s2);
		drain();
		write_cfg(CFG_FIRST0, f0);
		write_cfg(CFG_FIRST1, f1);
		write_cfg(CFG_FIRST2, f2);
		write_cfg(CFG_START0, s0);
		write_cfg(CFG_START1, s1);
		write_cfg(CFG_START2, s2);
	endtask

	task automatic random_request(int release_pct);
		logic [1:0] mode;
		logic [1:0] cls;
		logic [4:0] idx;
		int         roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			mode = MODE_RESET;
		else if (roll < 4 + (96 - release_pct) / 2)
			mode = MODE_ANY;
		else if (roll < 100 - release_pct)
			mode = MODE_SPECIFIC;
		else
			mode = MODE_RELEASE;
		cls = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		idx = ($urandom_range(0, 11) == 0) ? 5'($urandom_range(24, 31))
		                                   : 5'($urandom_range(0, 23));
		send_request(mode, cls, idx);
	endtask

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default configuration: nothing reserved until a pool reset.
		send_request(MODE_ANY, 2'd0, 5'($urandom));
		send_request(MODE_ANY, 2'd1, 5'($urandom));
		send_request(MODE_ANY, 2'd2, 5'($urandom));
		send_request(MODE_ANY, 2'd3, 5'($urandom));
		send_request(MODE_SPECIFIC, 2'($urandom), 5'd7);
		send_request(MODE_SPECIFIC, 2'($urandom), 5'd0);
		send_request(MODE_SPECIFIC, 2'($urandom), 5'd24);
		send_request(MODE_SPECIFIC, 2'($urandom), 5'd31);
		send_request(MODE_RELEASE, 2'($urandom), 5'd31);
		send_request(MODE_RELEASE, 2'($urandom), 5'd7);
		send_request(MODE_RELEASE, 2'($urandom), 5'd7);
		send_request(MODE_RESET, 2'd3, 5'($urandom));

		// Class 0 fully reserved, class 2 partly reserved with a zero count.
		load_setting(0, 16, 20, 0, 8, 0);
		send_request(MODE_RESET, 2'd0, 5'($urandom));
		send_request(MODE_ANY, 2'd0, 5'($urandom));
		send_request(MODE_SPECIFIC, 2'($urandom), 5'd3);
		send_request(MODE_RELEASE, 2'($urandom), 5'd3);
		send_request(MODE_ANY, 2'd0, 5'($urandom));
		send_request(MODE_ANY, 2'd0, 5'($urandom));
		send_request(MODE_ANY, 2'd2, 5'($urandom));
		send_request(MODE_ANY, 2'd1, 5'($urandom));
		send_request(MODE_RESET, 2'd2, 5'($urandom));
		send_request(MODE_RELEASE, 2'($urandom), 5'd23);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: load_setting(8, 16, 24, 8, 8, 8);
				1: load_setting(0, 8, 16, 0, 0, 0);
				2: load_setting(4, 12, 20, 8, 3, 5);
				default: load_setting($urandom_range(0, 8), $urandom_range(8, 16),
					$urandom_range(16, 24), $urandom_range(0, 8),
					$urandom_range(0, 8), $urandom_range(0, 8));
			endcase
			calm = (p % 3 == 2);
			send_request(MODE_RESET, 2'($urandom), 5'($urandom));
			repeat (250) random_request((p % 4 == 3) ? 60 : 30);
		end

		calm = 1'b0;
		drain();
		repeat (30) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rpa_pkg.sv
hdl/register_pool_allocator_unit.sv
hdl/rpa_checker.sv
dv/register_pool_allocator_unit_checker.sv
dv/register_pool_allocator_unit_tb.sv
